/* hdl/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
// Holds the transaction structs, opcode and status codes, and the default depth.
// No dependencies.
package spq_pkg;

  // Default number of storage cells.
  localparam int unsigned DefaultDepth = 8;

  // Widths fixed by the transaction format.
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 4;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Input transaction.
  typedef struct packed {
    op_e                      op;
    logic signed [ValueW-1:0] item_value;
  } in_t;

  // Result transaction.
  typedef struct packed {
    status_e                  status;
    logic [CountW-1:0]        entry_count;
    logic signed [ValueW-1:0] head_value;
  } out_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                     wr_en;
    op_e                      op;
    logic signed [ValueW-1:0] value;
  } cell_ctl_t;

  // Flags one cell reports to its neighbors and to the control logic.
  typedef struct packed {
    logic ins;   // Cell sits at or after the insert position.
    logic del;   // Cell sits at or after the first match of a delete.
    logic eq;    // Cell is occupied and holds the searched value.
  } cell_flags_t;

endpackage

/* hdl/sorted_priority_queue_core.sv */
// Sorted priority queue built as a chain of compare-and-shift cells.
// The result of a transaction is registered and valid in the cycle after it is accepted.
// Throughput: one transaction per cycle unless the output stalls; every cell compares
// and shifts in parallel, and the found flag is one OR over the cells' match flags.
// Reset: the fill count and the output valid clear asynchronously; cell contents
// are not reset and only entries below the fill count are ever read.
module sorted_priority_queue_core #(
  parameter int unsigned DEPTH = spq_pkg::DefaultDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  spq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output spq_pkg::out_t out_data_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]          count_q;
  logic [CntW-1:0]          count_d;
  logic                     out_valid_q;
  out_t                     out_data_q;
  out_t                     out_data_d;
  logic                     accept;
  logic                     full;
  logic                     found;
  logic                     do_write;
  cell_ctl_t                ctl;
  status_e                  status;
  logic signed [ValueW-1:0] head;

  logic signed [ValueW-1:0] values [DEPTH];
  cell_flags_t              flags  [DEPTH];
  logic [DEPTH-1:0]         eq_vec;

  // Input handshake: the output register frees as soon as its result is taken.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign full       = count_q == CntW'(DEPTH);

  // Chain of cells.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic                     left_ins;
    logic signed [ValueW-1:0] left_value;
    logic signed [ValueW-1:0] right_value;

    if (k == 0) begin : g_first
      assign left_ins   = 1'b0;
      assign left_value = values[k];
    end else begin : g_mid
      assign left_ins   = flags[k-1].ins;
      assign left_value = values[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign right_value = values[k];
    end else begin : g_inner
      assign right_value = values[k+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .occ_i        (CntW'(k) < count_q),
      .tail_i       (CntW'(k) == count_q),
      .left_ins_i   (left_ins),
      .left_value_i (left_value),
      .right_value_i(right_value),
      .flags_o      (flags[k]),
      .value_o      (values[k])
    );

    assign eq_vec[k] = flags[k].eq;
  end

  assign found = |eq_vec;

  // Decide status, write enable and the new fill count.
  always_comb begin
    status   = ST_OK;
    do_write = 1'b0;
    count_d  = count_q;
    case (in_data_i.op)
      OP_INSERT: begin
        if (full) begin
          status = ST_OVERFLOW;
        end else begin
          do_write = accept;
          count_d  = count_q + CntW'(1);
        end
      end
      OP_DELETE: begin
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else if (!found) begin
          status = ST_NOT_FOUND;
        end else begin
          do_write = accept;
          count_d  = count_q - CntW'(1);
        end
      end
      default: status = ST_OK;
    endcase
  end

  // Command to the cells.
  always_comb begin
    ctl.wr_en = do_write;
    ctl.op    = in_data_i.op;
    ctl.value = in_data_i.item_value;
  end

  // Head after the operation, taken from what cell zero will hold.
  always_comb begin
    head = values[0];
    if (status == ST_OK) begin
      case (in_data_i.op)
        OP_INSERT: head = flags[0].ins ? in_data_i.item_value : values[0];
        OP_DELETE: head = flags[0].del ? values[1] : values[0];
        default:   head = values[0];
      endcase
    end
    if (count_d == '0) begin
      head = '0;
    end
  end

  always_comb begin
    out_data_d.status      = status;
    out_data_d.entry_count = CountW'(count_d);
    out_data_d.head_value  = head;
  end

  // Fill count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("fill count exceeds depth");

  // An accepted insert into a queue with room grows the count by one.
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.op == OP_INSERT && !full |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not grow the count");

  // The reported count matches the stored count after each transaction.
  a_count_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_data_q.entry_count == CountW'(count_q))
    else $error("reported count differs from stored count");

  // The two front entries stay in descending order.
  a_front_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= CntW'(2) |-> values[0] >= values[1])
    else $error("front entries out of order");
`endif

endmodule

/* hdl/spq_cell.sv */
// One storage cell of the sorted queue chain.
// Compares its entry with the broadcast value and shifts toward either neighbor.
// Depends on spq_pkg.
module spq_cell (
  input  logic                               clk_i,
  input  spq_pkg::cell_ctl_t                 ctl_i,
  input  logic                               occ_i,
  input  logic                               tail_i,
  input  logic                               left_ins_i,
  input  logic signed [spq_pkg::ValueW-1:0]  left_value_i,
  input  logic signed [spq_pkg::ValueW-1:0]  right_value_i,
  output spq_pkg::cell_flags_t               flags_o,
  output logic signed [spq_pkg::ValueW-1:0]  value_o
);
  import spq_pkg::*;

  logic signed [ValueW-1:0] entry_q;
  logic signed [ValueW-1:0] entry_d;
  logic                     ge;

  // Local compare against the broadcast value.
  always_comb begin
    ge          = ctl_i.value >= entry_q;
    flags_o.ins = occ_i ? ge : tail_i;
    flags_o.del = occ_i & ge;
    flags_o.eq  = occ_i & (ctl_i.value == entry_q);
  end

  // Insert shifts toward the tail, delete pulls from the tail side.
  always_comb begin
    entry_d = entry_q;
    case (ctl_i.op)
      OP_INSERT: begin
        if (left_ins_i) begin
          entry_d = left_value_i;
        end else if (flags_o.ins) begin
          entry_d = ctl_i.value;
        end
      end
      OP_DELETE: begin
        if (flags_o.del) begin
          entry_d = right_value_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  // Entry storage; no reset, contents are qualified by the fill count.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      entry_q <= entry_d;
    end
  end

  assign value_o = entry_q;

endmodule

/* tb/sorted_priority_queue_core_test.sv */
// Self-checking testbench for the sorted priority queue core.
// Sends insert and delete transactions, predicts each result from its own copy of the queue,
// and checks the results in order. Depends on spq_pkg and sorted_priority_queue_core.
module sorted_priority_queue_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int unsigned QueueDepth   = DefaultDepth;
  localparam int unsigned IdlePct      = 7;
  localparam int unsigned HoldCycles   = 200;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned DrainLimit   = 1000;
  localparam int unsigned SettleCycles = 4;
  localparam logic signed [ValueW-1:0] MaxValue = {1'b0, {(ValueW-1){1'b1}}};
  localparam logic signed [ValueW-1:0] MinValue = {1'b1, {(ValueW-1){1'b0}}};

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  // Predicted queue contents, largest value first.
  logic signed [ValueW-1:0] model_entries[$];
  // Results predicted for accepted transactions, oldest first.
  out_t expected_results[$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit quiet_mode = 1'b0;
  bit hold_req = 1'b0;
  bit fill_phase = 1'b1;

  sorted_priority_queue_core #(
    .DEPTH(QueueDepth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Free-running clock.
  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort the run if it takes far longer than any correct run could.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Apply one operation to the predicted queue and return the result it should produce.
  function automatic out_t apply_queue_op(op_e op, logic signed [ValueW-1:0] value);
    out_t res;
    int   pos;
    res.status = ST_OK;
    if (op == OP_INSERT) begin
      if (model_entries.size() >= QueueDepth) begin
        res.status = ST_OVERFLOW;
      end else begin
        // The new value goes ahead of the first entry that is not larger than it.
        pos = model_entries.size();
        for (int k = 0; k < model_entries.size(); k++) begin
          if (pos == model_entries.size() && value >= model_entries[k]) pos = k;
        end
        model_entries.insert(pos, value);
      end
    end else if (model_entries.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      pos = -1;
      for (int k = 0; k < model_entries.size(); k++) begin
        if (pos < 0 && model_entries[k] == value) pos = k;
      end
      if (pos < 0) res.status = ST_NOT_FOUND;
      else model_entries.delete(pos);
    end
    res.entry_count = CountW'(model_entries.size());
    res.head_value  = (model_entries.size() != 0) ? model_entries[0] : '0;
    return res;
  endfunction

  // Offer one transaction, wait for acceptance, then record its predicted result.
  // Valid stays high afterwards so back-to-back transactions need no gap.
  task automatic send_item(op_e op, logic signed [ValueW-1:0] value);
    while (!quiet_mode && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{op: op, item_value: value};
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(apply_queue_op(op, value));
  endtask

  // Random traffic that sweeps between a full and an empty queue.
  task automatic run_random_items(int unsigned count);
    op_e                      op;
    logic signed [ValueW-1:0] value;
    int unsigned              pick;
    repeat (count) begin
      if (model_entries.size() >= QueueDepth) fill_phase = 1'b0;
      else if (model_entries.size() == 0) fill_phase = 1'b1;
      op = (($urandom_range(99) < 75) == fill_phase) ? OP_INSERT : OP_DELETE;
      pick = $urandom_range(99);
      // Deletes mostly target stored values; small values make duplicates common.
      if (op == OP_DELETE && model_entries.size() != 0 && pick < 70)
        value = model_entries[$urandom_range(model_entries.size() - 1)];
      else if (pick < 85)
        value = $urandom_range(16) - 32'd8;
      else
        value = $urandom;
      send_item(op, value);
    end
  endtask

  // Extreme values, duplicates, overflow, not found and deletes on an empty queue.
  task automatic test_directed_extremes();
    send_item(OP_DELETE, '0);
    send_item(OP_INSERT, MaxValue);
    send_item(OP_INSERT, MinValue);
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, -1);
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, 1);
    send_item(OP_INSERT, MinValue);
    send_item(OP_INSERT, MaxValue);
    send_item(OP_INSERT, 5);
    send_item(OP_DELETE, 7);
    send_item(OP_DELETE, MaxValue);
    send_item(OP_DELETE, MaxValue);
    send_item(OP_DELETE, MinValue);
    send_item(OP_DELETE, '0);
    send_item(OP_DELETE, MinValue);
    send_item(OP_DELETE, '0);
    send_item(OP_DELETE, -1);
    send_item(OP_DELETE, 1);
    send_item(OP_DELETE, -1);
  endtask

  task automatic test_random_traffic(int unsigned count);
    run_random_items(count);
  endtask

  // The receiver holds off for a long time while transactions keep coming.
  task automatic test_back_pressure();
    hold_req <= 1'b1;
    run_random_items(40);
  endtask

  // A long stretch with neither side idling.
  task automatic test_quiet_stretch();
    quiet_mode = 1'b1;
    run_random_items(200);
    quiet_mode = 1'b0;
  endtask

  // Receiver: random stall, or a long hold-off when requested.
  initial begin : result_receiver
    int unsigned hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  <= 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet_mode && ($urandom_range(99) < IdlePct);
      end
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d count %0d head %0d",
               out_data_o.status, out_data_o.entry_count, out_data_o.head_value);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data_o.status);
          error_count++;
        end
        if (out_data_o.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d",
                 want.entry_count, out_data_o.entry_count);
          error_count++;
        end
        if (out_data_o.head_value !== want.head_value) begin
          $error("head_value: expected %0d, actual %0d",
                 want.head_value, out_data_o.head_value);
          error_count++;
        end
      end
    end
  end

  // Test sequence.
  initial begin : run_tests
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    test_random_traffic(450);
    test_back_pressure();
    test_quiet_stretch();
    test_random_traffic(400);

    // Drain outstanding results, then watch for stray ones.
    in_valid_i <= 1'b0;
    for (int i = 0; i < DrainLimit && expected_results.size() != 0; i++) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d predicted results never arrived", expected_results.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue_core.sv
tb/sorted_priority_queue_core_test.sv
